### hw/rtl/grid_ternary_window_match_top_defines.svh
// Assertion macros used by the back end of the grid window match RTL.
`ifndef GRID_TERNARY_WINDOW_MATCH_TOP_DEFINES_SVH
`define GRID_TERNARY_WINDOW_MATCH_TOP_DEFINES_SVH

`ifndef SYNTH
`define GTWM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gtwm: same-cycle check failed");
`define GTWM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gtwm: next-cycle check failed");
`else
`define GTWM_ASSERT_IMP(lbl, ante, cons)
`define GTWM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/gtwm_pkg.sv
// Types, codes and helpers shared by the grid window match block.
package gtwm_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_MATCH_MODE  = 3'd0;
  localparam logic [2:0] REG_TILE_WIDTH  = 3'd1;
  localparam logic [2:0] REG_TILE_HEIGHT = 3'd2;
  localparam logic [2:0] REG_TILE_CELLS  = 3'd3;
  localparam logic [2:0] REG_GRID_WIDTH  = 3'd4;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd5;

  // Layout cell codes
  localparam logic [1:0] CELL_DISABLED = 2'd0;
  localparam logic [1:0] CELL_ENABLED  = 2'd1;
  localparam logic [1:0] CELL_NO_SPACE = 2'd2;

  // Match modes
  localparam logic MODE_RULE   = 1'b0;
  localparam logic MODE_FORBID = 1'b1;

  // Request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  // Tile codes held in the 32-bit register: 16 codes of 2 bits
  localparam int TILE_CODES = 16;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_TEST,
    CMD_NOFIT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [5:0] x;
    logic [5:0] y;
    logic [1:0] code;
  } cmd_t;

  // Effective (clamped) configuration
  typedef struct packed {
    logic        mode;
    logic [3:0]  tw;
    logic [3:0]  th;
    logic [5:0]  gw;
    logic [5:0]  gh;
    logic [31:0] cells;
  } cfg_t;

  // Does one tile code accept the cell below it
  function automatic logic cell_ok(logic mode, logic [1:0] t, logic [1:0] c);
    logic r;
    case (t)
      CELL_ENABLED:  r = (c == CELL_ENABLED);
      CELL_DISABLED: r = (mode == MODE_FORBID) ? (c == CELL_DISABLED)
                                               : ((c == CELL_DISABLED) || (c == CELL_NO_SPACE));
      default:       r = (mode == MODE_FORBID) ? (c != CELL_NO_SPACE) : 1'b1;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/gtwm_ram.sv
// Generic simple dual-port RAM with registered read.
module gtwm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/gtwm_front.sv
// Front end: accept requests, drop out-of-layout writes, classify tests.
module gtwm_front import gtwm_pkg::*; (
  input  logic       start,
  input  logic       full,
  input  logic       opcode,
  input  logic [5:0] pos_x,
  input  logic [5:0] pos_y,
  input  logic [1:0] cell_code,
  input  cfg_t       cfg,
  output logic       push,
  output cmd_t       cmd
);

  logic [7:0] pad_w;
  logic [7:0] pad_h;
  logic       fits;
  logic       in_layout;

  // padded size: layout plus a frame of tile size less one on each side
  assign pad_w = 8'(cfg.gw) + {3'b000, cfg.tw - 4'd1, 1'b0};
  assign pad_h = 8'(cfg.gh) + {3'b000, cfg.th - 4'd1, 1'b0};
  assign fits  = ((8'(pos_x) + 8'(cfg.tw)) <= pad_w) &&
                 ((8'(pos_y) + 8'(cfg.th)) <= pad_h);
  assign in_layout = (pos_x < cfg.gw) && (pos_y < cfg.gh);

  always_comb begin
    cmd.x    = pos_x;
    cmd.y    = pos_y;
    cmd.code = cell_code;
    if (opcode == OP_WRITE) begin
      cmd.kind = CMD_WRITE;
    end else if (fits) begin
      cmd.kind = CMD_TEST;
    end else begin
      cmd.kind = CMD_NOFIT;
    end
  end

  // drop writes outside the layout
  assign push = start && !full && ((opcode == OP_TEST) || in_layout);

endmodule

### hw/rtl/gtwm_queue.sv
// Two-entry command queue between front and back.
module gtwm_queue import gtwm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t              entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/gtwm_back.sv
// Back end: perform layout writes and scan the tile window cell by cell.
`include "grid_ternary_window_match_top_defines.svh"
module gtwm_back import gtwm_pkg::*; #(
  parameter int GRID_MAX = 32,
  parameter int TILE_MAX = 4,
  localparam int AW = (GRID_MAX * GRID_MAX > 1) ? $clog2(GRID_MAX * GRID_MAX) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          empty,
  input  cmd_t          head,
  output logic          pop,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [1:0]    wr_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [1:0]    rd_data,
  output logic          done,
  output logic          match,
  output logic          window_fits
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  state_t     state;
  logic [5:0] bx;
  logic [5:0] by;
  logic [2:0] ci;
  logic [2:0] cj;
  logic       ok;
  logic       p_valid;
  logic       p_frame;
  logic [1:0] p_tcode;
  logic       p_last;

  logic       issue;
  logic       last_i;
  logic       last_j;
  logic [3:0] ox;
  logic [3:0] oy;
  logic [6:0] px;
  logic [6:0] py;
  logic [6:0] lx;
  logic [6:0] ly;
  logic       frame;
  logic [6:0] tidx;
  logic [1:0] tcode;
  logic [1:0] lay_code;
  logic       cok;

  assign pop     = (state == S_IDLE) && !empty;
  assign wr_en   = pop && (head.kind == CMD_WRITE);
  assign wr_addr = AW'(int'(head.y) * GRID_MAX + int'(head.x));
  assign wr_data = head.code;

  // address stage
  assign issue  = (state == S_SCAN);
  assign last_i = (4'(ci) == cfg.tw - 4'd1);
  assign last_j = (4'(cj) == cfg.th - 4'd1);
  assign ox     = cfg.tw - 4'd1;
  assign oy     = cfg.th - 4'd1;
  assign px     = 7'(bx) + 7'(ci);
  assign py     = 7'(by) + 7'(cj);
  assign lx     = px - 7'(ox);
  assign ly     = py - 7'(oy);
  assign frame  = (px < 7'(ox)) || (py < 7'(oy)) ||
                  (lx >= 7'(cfg.gw)) || (ly >= 7'(cfg.gh));
  assign rd_en   = issue && !frame;
  assign rd_addr = AW'(int'(ly) * GRID_MAX + int'(lx));
  assign tidx    = 7'(int'(ci) * TILE_MAX + int'(cj));
  assign tcode   = (tidx >= 7'(TILE_CODES)) ? CELL_DISABLED : cfg.cells[{tidx[3:0], 1'b0} +: 2];

  // compare stage
  assign lay_code = p_frame ? CELL_DISABLED : rd_data;
  assign cok      = cell_ok(cfg.mode, p_tcode, lay_code);

  always_ff @(posedge clk) begin
    p_frame <= frame;
    p_tcode <= tcode;
    p_last  <= last_i && last_j;
    if (p_valid) begin
      ok <= ok && cok;
    end
    if (p_valid && p_last) begin
      match       <= ok && cok;
      window_fits <= 1'b1;
    end
    if (pop) begin
      if (head.kind == CMD_NOFIT) begin
        match       <= 1'b0;
        window_fits <= 1'b0;
      end
      bx <= head.x;
      by <= head.y;
      ci <= '0;
      cj <= '0;
      ok <= 1'b1;
    end
    if (issue) begin
      if (last_j) begin
        cj <= '0;
        ci <= ci + 3'd1;
      end else begin
        cj <= cj + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      p_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      p_valid <= issue;
      done    <= (p_valid && p_last) || (pop && (head.kind == CMD_NOFIT));
      case (state)
        S_IDLE: begin
          if (pop && (head.kind == CMD_TEST)) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (last_i && last_j) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (p_valid && p_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `GTWM_ASSERT_IMP(a_pop_nonempty, pop, !empty)
  `GTWM_ASSERT_NXT(a_scan_issue, state == S_SCAN, p_valid)
  `GTWM_ASSERT_NXT(a_last_done, p_valid && p_last, done && window_fits)
  `GTWM_ASSERT_IMP(a_nofit_nomatch, done && !window_fits, !match)

endmodule

### hw/rtl/grid_ternary_window_match_top.sv
// Top level of the grid ternary window match block.
//
// Keeps a layout grid of 2-bit cells (disabled, enabled, no space) and tests a
// configured tile of up to TILE_MAX x TILE_MAX codes against it. A request with
// opcode write stores one cell; a write outside the current layout is dropped
// and gives no result. A request with opcode test places the tile's corner at
// (pos_x, pos_y) in the padded space, the layout framed by tile_width-1 columns
// and tile_height-1 rows of disabled cells on each side, and gives exactly one
// result: window_fits, and match (zero whenever the window does not fit).
// A request is taken at a clock edge with start high and busy low. Each result
// is shown on match and window_fits for one cycle with done high; the receiver
// cannot stall it, so sample it in that cycle. Results come in request order.
// Flow: requests enter a two-entry queue; busy rises only while that queue is
// full. The back end finishes a write or a test that does not fit as it takes it
// from the queue; a fitting test scans the tile window through the single read
// port of the layout memory, one cell per cycle, and the next request waits
// until its result is out. The layout memory has no clearing pass and is ready
// right after reset; a test must only cover layout cells already written.
// Configuration: write registers through cfg_write/cfg_index/cfg_data only while
// no request is in flight. Out-of-range tile sizes are clamped to 1..TILE_MAX and
// grid sizes to at most GRID_MAX; a grid size of zero leaves only frame cells.
module grid_ternary_window_match_top import gtwm_pkg::*; #(
  parameter int GRID_MAX = 32,
  parameter int TILE_MAX = 4
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [5:0]  pos_x,
  input  logic [5:0]  pos_y,
  input  logic [1:0]  cell_code,
  // result channel
  output logic        done,
  output logic        match,
  output logic        window_fits,
  // configuration write port
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = (GRID_MAX * GRID_MAX > 1) ? $clog2(GRID_MAX * GRID_MAX) : 1;

  // configuration registers as written
  logic        match_mode;
  logic [2:0]  tile_width;
  logic [2:0]  tile_height;
  logic [31:0] tile_cells;
  logic [5:0]  grid_width;
  logic [5:0]  grid_height;

  cfg_t cfg;

  logic          push;
  cmd_t          push_cmd;
  logic          pop;
  cmd_t          head;
  logic          full;
  logic          empty;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [1:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [1:0]    rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_mode  <= MODE_RULE;
      tile_width  <= 3'd1;
      tile_height <= 3'd1;
      tile_cells  <= '0;
      grid_width  <= 6'd32;
      grid_height <= 6'd32;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MATCH_MODE:  match_mode  <= cfg_data[0];
        REG_TILE_WIDTH:  tile_width  <= cfg_data[2:0];
        REG_TILE_HEIGHT: tile_height <= cfg_data[2:0];
        REG_TILE_CELLS:  tile_cells  <= cfg_data;
        REG_GRID_WIDTH:  grid_width  <= cfg_data[5:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[5:0];
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  // effective configuration: clamp tile sizes to 1..TILE_MAX, grid to GRID_MAX
  always_comb begin
    cfg.mode  = match_mode;
    cfg.cells = tile_cells;
    if (tile_width == 3'd0) begin
      cfg.tw = 4'd1;
    end else if (int'(tile_width) > TILE_MAX) begin
      cfg.tw = 4'(TILE_MAX);
    end else begin
      cfg.tw = 4'(tile_width);
    end
    if (tile_height == 3'd0) begin
      cfg.th = 4'd1;
    end else if (int'(tile_height) > TILE_MAX) begin
      cfg.th = 4'(TILE_MAX);
    end else begin
      cfg.th = 4'(tile_height);
    end
    cfg.gw = (int'(grid_width) > GRID_MAX) ? 6'(GRID_MAX) : grid_width;
    cfg.gh = (int'(grid_height) > GRID_MAX) ? 6'(GRID_MAX) : grid_height;
  end

  // hold off requests only while the command queue is full
  assign busy = full;

  gtwm_front u_front (
    .start     (start),
    .full      (full),
    .opcode    (opcode),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .cell_code (cell_code),
    .cfg       (cfg),
    .push      (push),
    .cmd       (push_cmd)
  );

  gtwm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  gtwm_back #(
    .GRID_MAX (GRID_MAX),
    .TILE_MAX (TILE_MAX)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .empty       (empty),
    .head        (head),
    .pop         (pop),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .done        (done),
    .match       (match),
    .window_fits (window_fits)
  );

  // layout store, cell (x,y) at y*GRID_MAX+x
  gtwm_ram #(
    .WIDTH (2),
    .DEPTH (GRID_MAX * GRID_MAX)
  ) u_layout (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

endmodule

### dv/gtwm_window_checker.sv
// Checker for the grid window match block: mirrors the layout and registers, predicts each test.
module gtwm_window_checker import gtwm_pkg::*; #(
  parameter int GRID_MAX = 32,
  parameter int TILE_MAX = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        opcode,
  input  logic [5:0]  pos_x,
  input  logic [5:0]  pos_y,
  input  logic [1:0]  cell_code,
  input  logic        done,
  input  logic        match,
  input  logic        window_fits,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        flush,
  output int          fail_count,
  output int          due_count,
  output int          n_checked,
  output int          n_matched,
  output int          n_nofit
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic match;
    logic fits;
  } window_res_t;

  logic        mode_q;
  logic [2:0]  tw_q;
  logic [2:0]  th_q;
  logic [31:0] cells_q;
  logic [5:0]  gw_q;
  logic [5:0]  gh_q;
  logic [1:0]  layout_copy [GRID_MAX*GRID_MAX];
  window_res_t window_due [$];

  function automatic int clamp_tile(int v);
    if (v == 0) return 1;
    return (v > TILE_MAX) ? TILE_MAX : v;
  endfunction

  function automatic int clamp_grid(int v);
    return (v > GRID_MAX) ? GRID_MAX : v;
  endfunction

  function automatic window_res_t predict_window(int x, int y);
    int gw, gh, tw, th, pw, ph, px, py, bitpos;
    logic [1:0] t, c;
    logic ok;
    window_res_t r;
    gw = clamp_grid(int'(gw_q));
    gh = clamp_grid(int'(gh_q));
    tw = clamp_tile(int'(tw_q));
    th = clamp_tile(int'(th_q));
    pw = gw + 2 * (tw - 1);
    ph = gh + 2 * (th - 1);
    r.fits = (x + tw <= pw) && (y + th <= ph);
    ok = r.fits;
    for (int i = 0; i < tw; i++) begin
      for (int j = 0; j < th; j++) begin
        if (ok) begin
          bitpos = 2 * (i * TILE_MAX + j);
          t = (bitpos >= 32) ? CELL_DISABLED : cells_q[bitpos +: 2];
          px = x + i - (tw - 1);
          py = y + j - (th - 1);
          // frame cells read as disabled
          if (px < 0 || py < 0 || px >= gw || py >= gh) c = CELL_DISABLED;
          else c = layout_copy[py * GRID_MAX + px];
          if (t == CELL_ENABLED) begin
            ok = (c == CELL_ENABLED);
          end else if (t == CELL_DISABLED) begin
            if (mode_q == MODE_RULE) ok = (c == CELL_DISABLED) || (c == CELL_NO_SPACE);
            else ok = (c == CELL_DISABLED);
          end else if (mode_q == MODE_FORBID) begin
            ok = (c != CELL_NO_SPACE);
          end
        end
      end
    end
    r.match = ok;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < 50) $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    window_res_t exp_res;
    if (rst) begin
      mode_q     = MODE_RULE;
      tw_q       = 3'd1;
      th_q       = 3'd1;
      cells_q    = '0;
      gw_q       = 6'd32;
      gh_q       = 6'd32;
      window_due.delete();
      fail_count = 0;
      n_checked  = 0;
      n_matched  = 0;
      n_nofit    = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_MATCH_MODE:  mode_q  = cfg_data[0];
          REG_TILE_WIDTH:  tw_q    = cfg_data[2:0];
          REG_TILE_HEIGHT: th_q    = cfg_data[2:0];
          REG_TILE_CELLS:  cells_q = cfg_data;
          REG_GRID_WIDTH:  gw_q    = cfg_data[5:0];
          REG_GRID_HEIGHT: gh_q    = cfg_data[5:0];
          default: ;
        endcase
      end
      // results first, so a request taken at the same edge cannot be paired with them
      if (done) begin
        if (window_due.size() == 0) begin
          report_mismatch($sformatf("result with none outstanding: match=%0b fits=%0b",
                                    match, window_fits));
        end else begin
          exp_res = window_due.pop_front();
          if (window_fits !== exp_res.fits)
            report_mismatch($sformatf("result %0d window_fits=%b, want %b",
                                      n_checked, window_fits, exp_res.fits));
          if (match !== exp_res.match)
            report_mismatch($sformatf("result %0d match=%b, want %b",
                                      n_checked, match, exp_res.match));
          if (exp_res.match) n_matched++;
          if (!exp_res.fits) n_nofit++;
          n_checked++;
        end
      end
      if (start && !busy) begin
        if (opcode == OP_WRITE) begin
          if (int'(pos_x) < clamp_grid(int'(gw_q)) && int'(pos_y) < clamp_grid(int'(gh_q)))
            layout_copy[pos_y * GRID_MAX + pos_x] = cell_code;
        end else begin
          window_due.insert(window_due.size(), predict_window(int'(pos_x), int'(pos_y)));
        end
      end
      if (flush) begin
        while (window_due.size() != 0) begin
          exp_res = window_due.pop_front();
          report_mismatch($sformatf("test result never came: match=%0b fits=%0b",
                                    exp_res.match, exp_res.fits));
        end
      end
    end
    due_count = window_due.size();
  end

endmodule

### dv/tb_top.sv
// Testbench top for the grid window match block: stimulus, configuration phases and verdict.
module tb_top import gtwm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_MAX      = 32;
  localparam int TILE_MAX      = 4;
  localparam int ITEM_TARGET   = 575;     // directed part plus about 550 random requests
  localparam int PHASE_STEPS   = 40;
  localparam int SETTLE_CYCLES = 64;      // room for queued writes to drain before a register write
  localparam int CYCLE_LIMIT   = 500000;
  // stored code three has no name in the package
  localparam logic [1:0] CELL_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic        opcode;
  logic [5:0]  pos_x;
  logic [5:0]  pos_y;
  logic [1:0]  cell_code;
  logic        done;
  logic        match;
  logic        window_fits;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        flush;

  int fail_count, due_count, n_checked, n_matched, n_nofit;

  // Shadow of the registers, so that stimulus can be steered towards the layout in use
  logic        mode_r;
  logic [31:0] cells_r;
  int          etw, eth, egw, egh;
  bit          layout_written [GRID_MAX*GRID_MAX];

  int n_items;        // requests that the block acts on (ignored writes excluded)
  int n_settings;
  int burst_left;
  bit req_live;       // start is held high for a request that is still to come
  int cycle_n;

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  grid_ternary_window_match_top #(
    .GRID_MAX(GRID_MAX),
    .TILE_MAX(TILE_MAX)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .cell_code  (cell_code),
    .done       (done),
    .match      (match),
    .window_fits(window_fits),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  gtwm_window_checker #(
    .GRID_MAX(GRID_MAX),
    .TILE_MAX(TILE_MAX)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .cell_code  (cell_code),
    .done       (done),
    .match      (match),
    .window_fits(window_fits),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .flush      (flush),
    .fail_count (fail_count),
    .due_count  (due_count),
    .n_checked  (n_checked),
    .n_matched  (n_matched),
    .n_nofit    (n_nofit)
  );

  // Watchdog: end the run if it hangs
  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_n, due_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Tile code of column i, row j, as the block reads it
  function automatic logic [1:0] tile_code_at(int i, int j);
    int bitpos;
    bitpos = 2 * (i * TILE_MAX + j);
    return (bitpos >= 32) ? CELL_DISABLED : cells_r[bitpos +: 2];
  endfunction

  // Pick a layout cell that the given tile code accepts in the current mode
  function automatic logic [1:0] agreeing_cell(logic [1:0] t);
    int v;
    if (t == CELL_ENABLED) return CELL_ENABLED;
    if (t == CELL_DISABLED) begin
      if (mode_r == MODE_FORBID) return CELL_DISABLED;
      return ($urandom_range(0, 1) == 0) ? CELL_DISABLED : CELL_NO_SPACE;
    end
    // don't-care: anything in rule mode, anything but no-space when forbidding
    if (mode_r == MODE_RULE) return 2'($urandom_range(0, 3));
    v = $urandom_range(0, 2);
    return (v == 0) ? CELL_DISABLED : (v == 1) ? CELL_ENABLED : CELL_SPARE;
  endfunction

  function automatic logic [2:0] pick_tile_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 3'd0;
    if (r == 1) return 3'($urandom_range(5, 7));
    return 3'($urandom_range(1, 4));
  endfunction

  function automatic logic [5:0] pick_grid_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 6'd0;
    if (r == 1) return 6'($urandom_range(33, 63));
    if (r == 2) return 6'd32;
    // keep most layouts small so that windows are cheap to fill
    return 6'($urandom_range(1, 8));
  endfunction

  // Present one request at a falling edge and hold it until taken; then either carry on
  // with the burst (start stays high for the next request) or drop start for a gap.
  task automatic send_req(input logic op, input logic [5:0] x, input logic [5:0] y,
                          input logic [1:0] code);
    opcode    <= op;
    pos_x     <= x;
    pos_y     <= y;
    cell_code <= code;
    start     <= 1'b1;
    req_live   = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_TEST) begin
      n_items++;
    end else if (x < egw && y < egh) begin
      n_items++;
      layout_written[y * GRID_MAX + x] = 1'b1;
    end
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start   <= 1'b0;
      req_live = 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(10, 30)) @(negedge clk);
      else repeat ($urandom_range(1, 4)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // Drop start if a burst left it high
  task automatic quiesce();
    if (req_live) begin
      start   <= 1'b0;
      req_live = 1'b0;
      @(negedge clk);
    end
  endtask

  // Hold off until every expected result has come
  task automatic wait_drained();
    quiesce();
    while (due_count != 0) @(negedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // Write all six registers with the block idle, and update the shadow copy
  task automatic apply_config(input logic m, input logic [2:0] tw, input logic [2:0] th,
                              input logic [31:0] cl, input logic [5:0] gw,
                              input logic [5:0] gh);
    wait_drained();
    // writes give no result, so allow any still queued to finish
    repeat (SETTLE_CYCLES) @(negedge clk);
    put_reg(REG_MATCH_MODE, {31'd0, m});
    put_reg(REG_TILE_WIDTH, {29'd0, tw});
    put_reg(REG_TILE_HEIGHT, {29'd0, th});
    put_reg(REG_TILE_CELLS, cl);
    put_reg(REG_GRID_WIDTH, {26'd0, gw});
    put_reg(REG_GRID_HEIGHT, {26'd0, gh});
    cfg_write <= 1'b0;
    mode_r  = m;
    cells_r = cl;
    etw = (tw == 0) ? 1 : (tw > TILE_MAX) ? TILE_MAX : tw;
    eth = (th == 0) ? 1 : (th > TILE_MAX) ? TILE_MAX : th;
    egw = (gw > GRID_MAX) ? GRID_MAX : gw;
    egh = (gh > GRID_MAX) ? GRID_MAX : gh;
    n_settings++;
  endtask

  // Prepare the layout under a window, then send the test request.
  // With agree set, fill the covered cells so that the tile accepts them, and now and
  // then spoil one cell; otherwise write only the cells not yet written.
  task automatic run_test(input int x, input int y, input bit agree);
    int px, py, flip_k, n;
    logic [1:0] c;
    flip_k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, etw * eth - 1) : -1;
    for (int i = 0; i < etw; i++) begin
      for (int j = 0; j < eth; j++) begin
        px = x + i - (etw - 1);
        py = y + j - (eth - 1);
        n  = i * eth + j;
        if (px >= 0 && px < egw && py >= 0 && py < egh) begin
          if (agree) begin
            c = (n == flip_k) ? 2'($urandom_range(0, 3)) : agreeing_cell(tile_code_at(i, j));
            send_req(OP_WRITE, 6'(px), 6'(py), c);
          end else if (!layout_written[py * GRID_MAX + px]) begin
            send_req(OP_WRITE, 6'(px), 6'(py), 2'($urandom_range(0, 3)));
          end
        end
      end
    end
    send_req(OP_TEST, 6'(x), 6'(y), 2'($urandom_range(0, 3)));
  endtask

  initial begin
    logic        m;
    logic [2:0]  tw, th;
    logic [31:0] cl;
    logic [5:0]  gw, gh;
    int phase, steps, pause_at, r, pw, ph, x, y;

    // Initialise every input of the block and hold reset
    rst        = 1'b1;
    start      = 1'b0;
    opcode     = OP_WRITE;
    pos_x      = '0;
    pos_y      = '0;
    cell_code  = CELL_DISABLED;
    cfg_write  = 1'b0;
    cfg_index  = REG_MATCH_MODE;
    cfg_data   = '0;
    flush      = 1'b0;
    req_live   = 1'b0;
    burst_left = 0;
    n_items    = 0;
    n_settings = 0;
    cycle_n    = 0;
    mode_r     = MODE_RULE;
    cells_r    = '0;
    etw = 1;
    eth = 1;
    egw = GRID_MAX;
    egh = GRID_MAX;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset settings, a 1x1 tile of disabled over the full 32x32 layout.
    // Corner cells, stored code three, a write outside the layout (dropped) and
    // windows that fall off the padded space.
    send_req(OP_WRITE, 6'd0, 6'd0, CELL_NO_SPACE);
    send_req(OP_WRITE, 6'd31, 6'd31, CELL_SPARE);
    send_req(OP_WRITE, 6'd32, 6'd5, CELL_ENABLED);
    send_req(OP_WRITE, 6'd0, 6'd31, CELL_ENABLED);
    send_req(OP_TEST, 6'd0, 6'd0, CELL_DISABLED);
    send_req(OP_TEST, 6'd31, 6'd31, CELL_SPARE);
    send_req(OP_TEST, 6'd0, 6'd31, CELL_ENABLED);
    send_req(OP_TEST, 6'd32, 6'd0, CELL_NO_SPACE);
    send_req(OP_TEST, 6'd0, 6'd37, CELL_DISABLED);

    // Directed: largest tile, all don't-care, forbidding, over a 2x2 layout of every code.
    // Windows at the top-left and bottom-right limits and one past the right or bottom limit.
    apply_config(MODE_FORBID, 3'd4, 3'd4, 32'hFFFF_FFFF, 6'd2, 6'd2);
    send_req(OP_WRITE, 6'd0, 6'd0, CELL_DISABLED);
    send_req(OP_WRITE, 6'd1, 6'd0, CELL_ENABLED);
    send_req(OP_WRITE, 6'd0, 6'd1, CELL_NO_SPACE);
    send_req(OP_WRITE, 6'd1, 6'd1, CELL_SPARE);
    send_req(OP_TEST, 6'd0, 6'd0, CELL_DISABLED);
    send_req(OP_TEST, 6'd4, 6'd4, CELL_ENABLED);
    send_req(OP_TEST, 6'd2, 6'd2, CELL_NO_SPACE);
    send_req(OP_TEST, 6'd5, 6'd0, CELL_SPARE);
    send_req(OP_TEST, 6'd0, 6'd5, CELL_DISABLED);
    send_req(OP_TEST, 6'd37, 6'd37, CELL_SPARE);

    // Directed: rule mode; an all-enabled tile fails on the frame, an all-disabled one
    // matches frame plus a disabled corner cell
    apply_config(MODE_RULE, 3'd4, 3'd4, 32'h5555_5555, 6'd2, 6'd2);
    send_req(OP_TEST, 6'd2, 6'd2, CELL_ENABLED);
    apply_config(MODE_RULE, 3'd4, 3'd4, 32'h0000_0000, 6'd2, 6'd2);
    send_req(OP_TEST, 6'd0, 6'd0, CELL_DISABLED);
    send_req(OP_TEST, 6'd1, 6'd1, CELL_ENABLED);

    // Random phases: the first few pin the extremes, the rest draw settings at random
    phase = 0;
    while (n_items < ITEM_TARGET) begin
      m  = 1'($urandom_range(0, 1));
      tw = pick_tile_size();
      th = pick_tile_size();
      r  = $urandom_range(0, 4);
      cl = (r == 0) ? 32'h0000_0000 : (r == 1) ? 32'h5555_5555 :
           (r == 2) ? 32'hFFFF_FFFF : (r == 3) ? 32'hAAAA_AAAA : 32'($urandom);
      gw = pick_grid_size();
      gh = pick_grid_size();
      case (phase)
        0: begin
          m = MODE_RULE;   tw = 3'd1; th = 3'd1; gw = 6'd32; gh = 6'd32;
        end
        1: begin
          m = MODE_FORBID; tw = 3'd4; th = 3'd4; gw = 6'd1;  gh = 6'd1;
        end
        2: begin
          // zero tile width acts as one; empty layout leaves only frame
          tw = 3'd0; th = 3'd7; gw = 6'd0; gh = 6'd63;
        end
        3: begin
          tw = 3'd7; th = 3'd0; gw = 6'd63; gh = 6'd5;
        end
        default: ;
      endcase
      apply_config(m, tw, th, cl, gw, gh);

      pw = egw + 2 * (etw - 1);
      ph = egh + 2 * (eth - 1);
      pause_at = $urandom_range(5, PHASE_STEPS - 5);
      steps = 0;
      while (steps < PHASE_STEPS && n_items < ITEM_TARGET) begin
        // hold off once per phase until the block has answered everything
        if (steps == pause_at) wait_drained();
        r = $urandom_range(0, 99);
        if (r < 12) begin
          // noise: a write anywhere, often outside the layout
          send_req(OP_WRITE, 6'($urandom_range(0, 37)), 6'($urandom_range(0, 37)),
                   2'($urandom_range(0, 3)));
        end else if (r < 22) begin
          // a test anywhere, many falling off the padded space
          run_test($urandom_range(0, 37), $urandom_range(0, 37), 1'b0);
        end else begin
          // a window that fits if any can, filled to agree with the tile more often than not
          x = (pw >= etw) ? $urandom_range(0, pw - etw) : $urandom_range(0, 37);
          y = (ph >= eth) ? $urandom_range(0, ph - eth) : $urandom_range(0, 37);
          run_test(x, y, r < 62);
        end
        steps++;
      end
      phase++;
    end

    // Drain: wait for every result, allow the tail of the pipeline, then flag leftovers
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    flush <= 1'b1;
    @(negedge clk);
    flush <= 1'b0;
    @(negedge clk);

    $display("Sent %0d requests over %0d register settings in both match modes", n_items,
             n_settings);
    $display("Checked %0d test results: %0d matched, %0d with the window off the padded space",
             n_checked, n_matched, n_nofit);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
